// ----- hw/rtl/jtlm_pkg.sv -----
// Shared types and constants for the joint trajectory limit monitor.
package jtlm_pkg;

	// Register and field widths.
	localparam int RATE_W       = 17;
	localparam int STEP_LIM_W   = 24;
	localparam int SAT_W        = 48;
	localparam int PEAK_STEP_W  = 24;
	localparam int STEP_CMP_W   = 32;
	localparam int ACC_PROD_W   = SAT_W + RATE_W;
	localparam int CFG_ADDR_W   = 2;
	localparam int CFG_DATA_W   = 48;

	// Result packing on the master side.
	localparam int OUT_DATA_W   = 120;
	localparam int OUT_USER_W   = 3;
	localparam int OUT_VEL_LSB  = PEAK_STEP_W;
	localparam int OUT_ACC_LSB  = PEAK_STEP_W + SAT_W;
	localparam int USER_STEP_HI = 0;
	localparam int USER_VEL_HI  = 1;
	localparam int USER_ACC_HI  = 2;

	// Register indexes.
	localparam logic [CFG_ADDR_W-1:0] REG_RATE_HZ   = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_STEP_LIM  = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_VEL_LIM   = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_ACC_LIM   = 2'd3;

	// Register reset values.
	localparam logic [RATE_W-1:0]     RATE_HZ_RST  = 17'd1000;
	localparam logic [STEP_LIM_W-1:0] STEP_LIM_RST = 24'd10486;
	localparam logic [SAT_W-1:0]      VEL_LIM_RST  = 48'd2280653;
	localparam logic [SAT_W-1:0]      ACC_LIM_RST  = 48'd15728640;

	// Sample counter codes within one trajectory.
	localparam logic [1:0] SAMPLES_NONE = 2'd0;
	localparam logic [1:0] SAMPLES_ONE  = 2'd1;
	localparam logic [1:0] SAMPLES_TWO  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic issue;
		logic emit;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last_joint;
		logic busy;
	} dp_status_t;

endpackage

// ----- hw/rtl/joint_trajectory_limit_monitor.sv -----
// Top level of the joint trajectory limit monitor.
//
// Usage: each item on the slave side carries one sample of JOINT_COUNT joint
// angles in s_tdata (joint 0 in the lowest POSITION_WIDTH bits) and a start
// flag in s_tuser that clears the history and the maxima before the sample.
// Each item produces one result on the master side: the running largest step,
// velocity and acceleration in m_tdata and three limit flags in m_tuser.
// Limits and the sample rate are written through the cfg_* port while idle.
// Timing: the joints are walked one per cycle through a shared step and
// multiply pipeline, which then drains (the first sample of a trajectory
// yields no step and the second no acceleration); the result is then loaded,
// and a new item is taken only once the previous result has been loaded.
// Reset: arst_n clears the maxima, the sample count and the handshakes and
// loads the register defaults. A stalled receiver holds the result; the next
// item is still accepted and worked on, and its result waits until the
// previous one has been taken.
module joint_trajectory_limit_monitor #(
	parameter int JOINT_COUNT    = 7,
	parameter int POSITION_WIDTH = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Fields from bit 0 up: joint_position_0 .. joint_position_N-1, zero fill.
	input  logic [((JOINT_COUNT*POSITION_WIDTH+7)/8)*8-1:0] s_tdata,
	// Fields from bit 0 up: start_of_trajectory.
	input  logic                                s_tuser,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// Fields from bit 0 up: largest step, max_velocity, max_acceleration.
	output logic [jtlm_pkg::OUT_DATA_W-1:0]     m_tdata,
	// Fields from bit 0 up: step_high, velocity_high, acceleration_high.
	output logic [jtlm_pkg::OUT_USER_W-1:0]     m_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic                                cfg_wr_en,
	input  logic [jtlm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [jtlm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	jtlm_pkg::ctrl_cmd_t  cmd;
	jtlm_pkg::dp_status_t status;

	logic [jtlm_pkg::PEAK_STEP_W-1:0] peak_step;
	logic [jtlm_pkg::SAT_W-1:0]       max_velocity;
	logic [jtlm_pkg::SAT_W-1:0]       max_acceleration;
	logic                             step_high;
	logic                             velocity_high;
	logic                             acceleration_high;

	jtlm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.status   (status)
	);

	jtlm_datapath #(
		.JOINT_COUNT    (JOINT_COUNT),
		.POSITION_WIDTH (POSITION_WIDTH)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_addr          (cfg_addr),
		.cfg_wdata         (cfg_wdata),
		.in_start          (s_tuser),
		.in_positions      (s_tdata[JOINT_COUNT*POSITION_WIDTH-1:0]),
		.peak_step         (peak_step),
		.max_velocity      (max_velocity),
		.max_acceleration  (max_acceleration),
		.step_high         (step_high),
		.velocity_high     (velocity_high),
		.acceleration_high (acceleration_high)
	);

	// Result packing.
	assign m_tdata = {max_acceleration, max_velocity, peak_step};
	assign m_tuser = {acceleration_high, velocity_high, step_high};

endmodule

// ----- hw/rtl/jtlm_datapath.sv -----
// Datapath: item capture, per-joint step and multiply pipeline, maxima and result register.
module jtlm_datapath #(
	parameter int JOINT_COUNT    = 7,
	parameter int POSITION_WIDTH = 24
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  jtlm_pkg::ctrl_cmd_t                    cmd,
	output jtlm_pkg::dp_status_t                   status,
	input  logic                                   cfg_wr_en,
	input  logic [jtlm_pkg::CFG_ADDR_W-1:0]        cfg_addr,
	input  logic [jtlm_pkg::CFG_DATA_W-1:0]        cfg_wdata,
	input  logic                                   in_start,
	input  logic [JOINT_COUNT*POSITION_WIDTH-1:0]  in_positions,
	output logic [jtlm_pkg::PEAK_STEP_W-1:0]       peak_step,
	output logic [jtlm_pkg::SAT_W-1:0]             max_velocity,
	output logic [jtlm_pkg::SAT_W-1:0]             max_acceleration,
	output logic                                   step_high,
	output logic                                   velocity_high,
	output logic                                   acceleration_high
);

	localparam int PW     = POSITION_WIDTH;
	localparam int JW     = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
	localparam int PROD_W = PW + jtlm_pkg::RATE_W;
	localparam int VEL_W  = (PROD_W > jtlm_pkg::SAT_W) ? PROD_W : jtlm_pkg::SAT_W + 1;
	localparam int SW     = jtlm_pkg::SAT_W;
	localparam int CW     = jtlm_pkg::STEP_CMP_W;
	localparam int AW     = jtlm_pkg::ACC_PROD_W;

	// Configuration registers.
	logic [jtlm_pkg::RATE_W-1:0]     rate_q;
	logic [jtlm_pkg::STEP_LIM_W-1:0] step_lim_q;
	logic [SW-1:0]                   vel_lim_q;
	logic [SW-1:0]                   acc_lim_q;

	// Captured item and joint walk.
	logic signed [PW-1:0] pos_q [JOINT_COUNT];
	logic [JW-1:0]        joint_q;
	logic [1:0]           samples_q;

	// Per-joint history.
	logic signed [PW-1:0] prev_pos_q  [JOINT_COUNT];
	logic [PW-1:0]        prev_step_q [JOINT_COUNT];

	// Pipeline registers.
	logic          valid_s1, has_acc_s1;
	logic [PW-1:0] step_s1, dd_s1;
	logic          valid_s2, has_acc_s2;
	logic [SW-1:0] vel_s2, acc1_s2;
	logic          valid_s3;
	logic [SW-1:0] acc_s3;

	// Running maxima.
	logic [PW-1:0] peak_step_q;
	logic [SW-1:0] max_vel_q;
	logic [SW-1:0] max_acc_q;

	// Stage 0 combinational values.
	logic signed [PW-1:0] cur_pos, cur_prev_pos;
	logic [PW-1:0]        cur_prev_step;
	logic signed [PW:0]   diff;
	logic [PW:0]          diff_mag;
	logic [PW-1:0]        step_c, dd_c;
	logic                 has_step, has_acc;

	// Multiplier outputs.
	logic [VEL_W-1:0] vel_prod, acc1_prod;
	logic [AW-1:0]    acc_prod;

	// Result formation.
	logic [CW-1:0]                    peak_step_ext;
	logic [jtlm_pkg::PEAK_STEP_W-1:0] peak_step_sat;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q     <= jtlm_pkg::RATE_HZ_RST;
			step_lim_q <= jtlm_pkg::STEP_LIM_RST;
			vel_lim_q  <= jtlm_pkg::VEL_LIM_RST;
			acc_lim_q  <= jtlm_pkg::ACC_LIM_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				jtlm_pkg::REG_RATE_HZ:  rate_q     <= cfg_wdata[jtlm_pkg::RATE_W-1:0];
				jtlm_pkg::REG_STEP_LIM: step_lim_q <= cfg_wdata[jtlm_pkg::STEP_LIM_W-1:0];
				jtlm_pkg::REG_VEL_LIM:  vel_lim_q  <= cfg_wdata[SW-1:0];
				jtlm_pkg::REG_ACC_LIM:  acc_lim_q  <= cfg_wdata[SW-1:0];
				default: ;
			endcase
		end
	end

	// Capture the joint positions of an accepted item.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int j = 0; j < JOINT_COUNT; j++) begin
				pos_q[j] <= in_positions[j*PW +: PW];
			end
		end
	end

	// Joint counter for the walk over the joints.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			joint_q <= '0;
		end else if (cmd.load) begin
			joint_q <= '0;
		end else if (cmd.issue) begin
			joint_q <= joint_q + JW'(1);
		end
	end

	assign status.last_joint = (joint_q == JW'(JOINT_COUNT - 1));
	assign status.busy       = valid_s1 | valid_s2 | valid_s3;

	// Sample count within the trajectory; a start flag restarts it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_q <= jtlm_pkg::SAMPLES_NONE;
		end else if (cmd.load && in_start) begin
			samples_q <= jtlm_pkg::SAMPLES_NONE;
		end else if (cmd.emit && samples_q != jtlm_pkg::SAMPLES_TWO) begin
			samples_q <= samples_q + 2'd1;
		end
	end

	// Step magnitude and change of step for the current joint.
	always_comb begin
		cur_pos       = pos_q[joint_q];
		cur_prev_pos  = prev_pos_q[joint_q];
		cur_prev_step = prev_step_q[joint_q];
		diff          = {cur_pos[PW-1], cur_pos} - {cur_prev_pos[PW-1], cur_prev_pos};
		diff_mag      = diff[PW] ? (~diff + (PW+1)'(1)) : diff;
		step_c        = diff_mag[PW-1:0];
		dd_c          = (step_c >= cur_prev_step) ? (step_c - cur_prev_step)
		                                          : (cur_prev_step - step_c);
		has_step      = (samples_q != jtlm_pkg::SAMPLES_NONE);
		has_acc       = (samples_q == jtlm_pkg::SAMPLES_TWO);
	end

	// History update and stage 1 payload.
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			prev_pos_q[joint_q] <= cur_pos;
			if (has_step) begin
				prev_step_q[joint_q] <= step_c;
			end
		end
		step_s1 <= step_c;
		dd_s1   <= dd_c;
	end

	// Stage 2: velocity and first acceleration product, both saturated.
	always_comb begin
		vel_prod  = VEL_W'(step_s1) * VEL_W'(rate_q);
		acc1_prod = VEL_W'(dd_s1) * VEL_W'(rate_q);
	end

	always_ff @(posedge clk) begin
		vel_s2  <= (|vel_prod[VEL_W-1:SW]) ? '1 : vel_prod[SW-1:0];
		acc1_s2 <= (|acc1_prod[VEL_W-1:SW]) ? '1 : acc1_prod[SW-1:0];
	end

	// Stage 3: second acceleration product, saturated.
	assign acc_prod = AW'(acc1_s2) * AW'(rate_q);

	always_ff @(posedge clk) begin
		acc_s3 <= (|acc_prod[AW-1:SW]) ? '1 : acc_prod[SW-1:0];
	end

	// Pipeline valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			has_acc_s1 <= 1'b0;
			valid_s2   <= 1'b0;
			has_acc_s2 <= 1'b0;
			valid_s3   <= 1'b0;
		end else begin
			valid_s1   <= cmd.issue & has_step;
			has_acc_s1 <= has_acc;
			valid_s2   <= valid_s1;
			has_acc_s2 <= has_acc_s1;
			valid_s3   <= valid_s2 & has_acc_s2;
		end
	end

	// Running maxima, cleared at the start of a trajectory.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_step_q <= '0;
			max_vel_q   <= '0;
			max_acc_q   <= '0;
		end else if (cmd.load && in_start) begin
			peak_step_q <= '0;
			max_vel_q   <= '0;
			max_acc_q   <= '0;
		end else begin
			if (valid_s1 && step_s1 > peak_step_q) begin
				peak_step_q <= step_s1;
			end
			if (valid_s2 && vel_s2 > max_vel_q) begin
				max_vel_q <= vel_s2;
			end
			if (valid_s3 && acc_s3 > max_acc_q) begin
				max_acc_q <= acc_s3;
			end
		end
	end

	// The reported step saturates at the field width; the limit check uses the full value.
	always_comb begin
		peak_step_ext = CW'(peak_step_q);
		peak_step_sat = (peak_step_ext > CW'({jtlm_pkg::PEAK_STEP_W{1'b1}}))
		                ? '1 : peak_step_ext[jtlm_pkg::PEAK_STEP_W-1:0];
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			peak_step         <= peak_step_sat;
			max_velocity      <= max_vel_q;
			max_acceleration  <= max_acc_q;
			step_high         <= (peak_step_ext > CW'(step_lim_q));
			velocity_high     <= (max_vel_q > vel_lim_q);
			acceleration_high <= (max_acc_q > acc_lim_q);
		end
	end

endmodule

// ----- hw/rtl/jtlm_ctrl.sv -----
// Controller: item handshakes and sequencing of the joint walk.
module jtlm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output jtlm_pkg::ctrl_cmd_t  cmd,
	input  jtlm_pkg::dp_status_t status
);

	jtlm_pkg::ctrl_state_t state_q, state_nxt;
	logic                  m_valid_q;
	logic                  out_free;

	assign out_free = !m_valid_q || m_tready;
	assign m_tvalid = m_valid_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jtlm_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			jtlm_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_nxt = jtlm_pkg::ST_RUN;
				end
			end
			jtlm_pkg::ST_RUN: begin
				if (status.last_joint) begin
					state_nxt = jtlm_pkg::ST_DRAIN;
				end
			end
			jtlm_pkg::ST_DRAIN: begin
				if (!status.busy) begin
					state_nxt = jtlm_pkg::ST_DONE;
				end
			end
			jtlm_pkg::ST_DONE: begin
				if (out_free) begin
					state_nxt = jtlm_pkg::ST_IDLE;
				end
			end
			default: state_nxt = jtlm_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the state machine.
	always_comb begin
		s_tready  = 1'b0;
		cmd.load  = 1'b0;
		cmd.issue = 1'b0;
		cmd.emit  = 1'b0;
		unique case (state_q)
			jtlm_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			jtlm_pkg::ST_RUN: begin
				cmd.issue = 1'b1;
			end
			jtlm_pkg::ST_DRAIN: ;
			jtlm_pkg::ST_DONE: begin
				cmd.emit = out_free;
			end
			default: ;
		endcase
	end

	// Result valid flag: set when a result is loaded, cleared when it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

`ifndef SYNTH
	// An accepted item starts the joint walk.
	a_accept_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == jtlm_pkg::ST_RUN))
		else $error("accepted item did not start the joint walk");

	// The pipeline is empty whenever the block waits for an item.
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == jtlm_pkg::ST_IDLE) |-> !status.busy)
		else $error("pipeline busy while idle");

	// A loaded result is presented on the next cycle.
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> m_tvalid)
		else $error("loaded result not presented");

	// A result is never loaded over one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!m_valid_q || m_tready))
		else $error("result overwritten before it was taken");
`endif

endmodule
